// ===== hdl/aho_pkg.sv =====
package aho_pkg;

   // Phase and harmonic series
   localparam int PHASE_BITS     = 24;
   localparam int HARMONICS      = 32;
   localparam int HARM_IDX_BITS  = $clog2(HARMONICS);
   localparam int LIMIT_BITS     = 6;

   // Quarter-wave sine table, entries 0 .. SINE_DEPTH inclusive
   localparam int SINE_DEPTH      = 1024;
   localparam int SINE_DEPTH_BITS = $clog2(SINE_DEPTH);
   localparam int SINE_ADDR_BITS  = SINE_DEPTH_BITS + 1;
   localparam int SINE_MAG_BITS   = 24;
   localparam int SINE_BITS       = SINE_MAG_BITS + 1;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Digit-serial multiplier: weights and amplitude are both Q1.15
   localparam int WEIGHT_BITS    = 16;
   localparam int AMP_BITS       = 16;
   localparam int DIGIT_BITS     = 4;
   localparam int DIGITS         = WEIGHT_BITS / DIGIT_BITS;
   localparam int DIGIT_CNT_BITS = $clog2(DIGITS);

   // Sum of all terms stays below 2^42 in magnitude, the scaled sum below 2^58.
   localparam int SUM_BITS  = 44;
   localparam int ACC_BITS  = SUM_BITS + AMP_BITS;
   localparam int OUT_BITS  = 24;
   // Q2.38 term times Q1.15 gain is Q.53; output is Q1.(OUT_BITS-1).
   localparam int RND_SHIFT = 54 - OUT_BITS;
   localparam int RES_BITS  = ACC_BITS - RND_SHIFT;
   localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS - 1){1'b1}}};
   localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS - 1){1'b0}}};

   // Configuration registers
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLITUDE      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HARMONIC_LIMIT = 2'd2;
   localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET     = 24'd167392;
   localparam logic [AMP_BITS-1:0]   AMPLITUDE_RESET      = 16'd8192;
   localparam logic [LIMIT_BITS-1:0] HARMONIC_LIMIT_RESET = 6'd32;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ROM [HARMONICS] = '{
      16'd32768, 16'd31130, 16'd28508, 16'd25231, 16'd21299, 16'd16712, 16'd12124, 16'd7537,
      16'd3604,  16'd0,     16'd2949,  16'd5243,  16'd6554,  16'd7209,  16'd6881,  16'd6226,
      16'd4915,  16'd3277,  16'd1638,  16'd0,     16'd1311,  16'd2621,  16'd3604,  16'd4260,
      16'd4260,  16'd3604,  16'd2949,  16'd1966,  16'd983,   16'd0,     16'd983,   16'd1966
   };

   typedef logic [SINE_DEPTH:0][SINE_MAG_BITS-1:0] sine_rom_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_MUL,
      ST_SUM,
      ST_SCALE,
      ST_ROUND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                     start;
      logic                     look;
      logic                     mul;
      logic                     sum;
      logic                     scale;
      logic                     round;
      logic                     first;
      logic [HARM_IDX_BITS-1:0] harmonic;
   } ctrl_type;

   // One table entry: Taylor series of sin in Q2.30, truncating at each step,
   // then rounded to Q1.23. Evaluated at elaboration only.
   function automatic logic [SINE_MAG_BITS-1:0] quarter_sine(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      x    = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      acc  = acc + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      acc  = acc + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      acc  = acc - $signed(term);
      if (acc < 0) begin
         acc = '0;
      end
      return SINE_MAG_BITS'((64'(acc) + 64'd64) >> 7);
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         rom[k] = quarter_sine(k);
      end
      return rom;
   endfunction

endpackage

// ===== hdl/aho_sine.sv =====
module aho_sine
   import aho_pkg::*;
(
   input  logic                        clock,
   input  ctrl_type                    ctrl,
   input  logic [PHASE_BITS-1:0]       phase_base,
   output logic signed [SINE_BITS-1:0] sine
);

   localparam sine_rom_type SineRom = build_sine_rom();

   logic [PHASE_BITS-1:0]     phase_ff;
   logic [PHASE_BITS-1:0]     hp_ff;
   logic [SINE_MAG_BITS-1:0]  rom_ff;
   logic                      neg_ff;
   logic [1:0]                quad;
   logic [SINE_DEPTH_BITS-1:0] raw_idx;
   logic [SINE_ADDR_BITS-1:0] addr;

   // Top two phase bits pick the quadrant; odd quadrants read the table backwards.
   assign quad    = hp_ff[PHASE_BITS-1 -: 2];
   assign raw_idx = hp_ff[PHASE_BITS-3 -: SINE_DEPTH_BITS];
   assign addr    = quad[0] ? SINE_ADDR_BITS'(SINE_DEPTH) - {1'b0, raw_idx}
                            : {1'b0, raw_idx};

   // Harmonic h sees h times the sample phase, built up by one add per harmonic.
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         phase_ff <= phase_base;
         hp_ff    <= '0;
      end else if (ctrl.look) begin
         hp_ff  <= hp_ff + phase_ff;
         rom_ff <= SineRom[addr];
         neg_ff <= quad[1];
      end
   end

   assign sine = neg_ff ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});

endmodule

// ===== hdl/aho_mac.sv =====
module aho_mac
   import aho_pkg::*;
(
   input  logic                        clock,
   input  ctrl_type                    ctrl,
   input  logic signed [SINE_BITS-1:0] sine,
   input  logic [AMP_BITS-1:0]         amplitude,
   output logic [OUT_BITS-1:0]         sample,
   output logic                        clipped
);

   localparam logic [ACC_BITS-1:0] RndHalf    = ACC_BITS'(1) << (RND_SHIFT - 1);
   localparam logic [ACC_BITS-1:0] RndHalfNeg = RndHalf + ACC_BITS'(1);

   logic [WEIGHT_BITS-1:0]              mult_sr_ff;
   logic signed [ACC_BITS-1:0]          acc_ff;
   logic signed [ACC_BITS-1:0]          acc_in;
   logic signed [SUM_BITS-1:0]          sum_ff;
   logic [ACC_BITS-1:0]                 mag_ff;
   logic [ACC_BITS-1:0]                 mag_in;
   logic                                neg_ff;
   logic [DIGIT_BITS-1:0]               digit;
   logic signed [SUM_BITS-1:0]          mcand;
   logic signed [SUM_BITS+DIGIT_BITS:0] prod;
   logic [RES_BITS-1:0]                 res;
   logic                                clip_pos;
   logic                                clip_neg;

   // Horner form, most significant digit first: acc = acc * 16 + mcand * digit.
   assign digit  = mult_sr_ff[WEIGHT_BITS-1 -: DIGIT_BITS];
   assign mcand  = ctrl.scale ? sum_ff : SUM_BITS'(sine);
   assign prod   = mcand * $signed({1'b0, digit});
   assign acc_in = (ctrl.first ? '0 : (acc_ff << DIGIT_BITS)) + ACC_BITS'(prod);

   // Magnitude plus half an output step, in one add: -a = ~a + 1.
   assign mag_in = (acc_ff[ACC_BITS-1] ? ~acc_ff : acc_ff)
                 + (acc_ff[ACC_BITS-1] ? RndHalfNeg : RndHalf);

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         acc_ff <= '0;
         sum_ff <= '0;
      end
      if (ctrl.look || ctrl.sum) begin
         // The finished term of the previous harmonic joins the sum here.
         sum_ff     <= sum_ff + $signed(acc_ff[SUM_BITS-1:0]);
         mult_sr_ff <= ctrl.look ? WEIGHT_ROM[ctrl.harmonic] : amplitude;
      end
      if (ctrl.mul || ctrl.scale) begin
         acc_ff     <= acc_in;
         mult_sr_ff <= mult_sr_ff << DIGIT_BITS;
      end
      if (ctrl.round) begin
         mag_ff <= mag_in;
         neg_ff <= acc_ff[ACC_BITS-1];
      end
   end

   assign res      = mag_ff[ACC_BITS-1:RND_SHIFT];
   assign clip_pos = !neg_ff && (res > RES_BITS'(OUT_MAX));
   assign clip_neg = neg_ff && (res > {{(RES_BITS - OUT_BITS){1'b0}}, OUT_MIN});
   assign clipped  = clip_pos || clip_neg;

   always_comb begin
      if (clip_pos) begin
         sample = OUT_MAX;
      end else if (clip_neg) begin
         sample = OUT_MIN;
      end else if (neg_ff) begin
         sample = -res[OUT_BITS-1:0];
      end else begin
         sample = res[OUT_BITS-1:0];
      end
   end

endmodule

// ===== hdl/aho_seq.sv =====
module aho_seq
   import aho_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [LIMIT_BITS-1:0] harmonic_limit,
   input  logic                  out_free,
   output logic                  req_ready,
   output logic                  out_load,
   output ctrl_type              ctrl
);

   localparam logic [DIGIT_CNT_BITS-1:0] DigitLast = DIGIT_CNT_BITS'(DIGITS - 1);

   state_type                 state_ff;
   state_type                 state_in;
   logic [HARM_IDX_BITS-1:0]  harm_ff;
   logic [DIGIT_CNT_BITS-1:0] digit_ff;
   logic [LIMIT_BITS-1:0]     limit_eff;
   logic                      digit_last;
   logic                      harm_last;

   assign limit_eff  = (harmonic_limit > LIMIT_BITS'(HARMONICS)) ? LIMIT_BITS'(HARMONICS)
                                                                  : harmonic_limit;
   assign digit_last = digit_ff == DigitLast;
   assign harm_last  = (LIMIT_BITS'(harm_ff) + LIMIT_BITS'(1)) == limit_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         harm_ff  <= '0;
         digit_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            harm_ff  <= '0;
            digit_ff <= '0;
         end else if (state_ff == ST_MUL || state_ff == ST_SCALE) begin
            digit_ff <= digit_last ? '0 : digit_ff + 1'b1;
            if (state_ff == ST_MUL && digit_last) begin
               harm_ff <= harm_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (limit_eff == '0) ? ST_SUM : ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (digit_last) begin
               state_in = harm_last ? ST_SUM : ST_LOOK;
            end
         end
         ST_SUM: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (digit_last) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = state_ff == ST_IDLE;
      out_load      = (state_ff == ST_FINISH) && out_free;
      ctrl.start    = accept;
      ctrl.look     = state_ff == ST_LOOK;
      ctrl.mul      = state_ff == ST_MUL;
      ctrl.sum      = state_ff == ST_SUM;
      ctrl.scale    = state_ff == ST_SCALE;
      ctrl.round    = state_ff == ST_ROUND;
      ctrl.first    = digit_ff == '0;
      ctrl.harmonic = harm_ff;
   end

endmodule

// ===== hdl/additive_harmonic_oscillator.sv =====
// Each accepted request sums n harmonic terms (n = 0..32), then scales by amplitude and rounds.
// A new request is taken only after the last sample reaches the output register; each harmonic
// costs one quarter-wave table read plus four radix-16 steps of the shared digit-serial MAC.
// A finished sample waits in the output register while the next request is taken.
// Reset is synchronous: the CSRs return to their defaults, the phase accumulator to zero,
// and any sample in flight or waiting is dropped. No initialization pass is needed.
module additive_harmonic_oscillator
   import aho_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,  // [0] restart
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [OUT_BITS-1:0]       rsp_tdata,  // [23:0] sample_out
   output logic                      rsp_tuser,  // [0] clipped
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [PHASE_BITS-1:0] phase_step_ff;
   logic [AMP_BITS-1:0]   amplitude_ff;
   logic [LIMIT_BITS-1:0] harmonic_limit_ff;
   logic [PHASE_BITS-1:0] phase_acc_ff;
   logic [PHASE_BITS-1:0] phase_base;
   logic                  rsp_valid_ff;
   logic [OUT_BITS-1:0]   rsp_sample_ff;
   logic                  rsp_clip_ff;
   logic                  accept;
   logic                  out_free;
   logic                  out_load;
   ctrl_type              ctrl;
   logic signed [SINE_BITS-1:0] sine;
   logic [OUT_BITS-1:0]   sample;
   logic                  clipped;

   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign phase_base = req_tdata[0] ? '0 : phase_acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff     <= PHASE_STEP_RESET;
         amplitude_ff      <= AMPLITUDE_RESET;
         harmonic_limit_ff <= HARMONIC_LIMIT_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PHASE_STEP:     phase_step_ff     <= csr_wdata[PHASE_BITS-1:0];
            CSR_AMPLITUDE:      amplitude_ff      <= csr_wdata[AMP_BITS-1:0];
            CSR_HARMONIC_LIMIT: harmonic_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            default:            ;
         endcase
      end
   end

   // The sample uses the phase as it stands on acceptance; the step is added right away.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
      end else if (accept) begin
         phase_acc_ff <= phase_base + phase_step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sample_ff <= sample;
         rsp_clip_ff   <= clipped;
      end
   end

   aho_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .harmonic_limit (harmonic_limit_ff),
      .out_free       (out_free),
      .req_ready      (req_tready),
      .out_load       (out_load),
      .ctrl           (ctrl)
   );

   aho_sine u_sine (
      .clock      (clock),
      .ctrl       (ctrl),
      .phase_base (phase_base),
      .sine       (sine)
   );

   aho_mac u_mac (
      .clock     (clock),
      .ctrl      (ctrl),
      .sine      (sine),
      .amplitude (amplitude_ff),
      .sample    (sample),
      .clipped   (clipped)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tuser  = rsp_clip_ff;

   assert property (@(posedge clock) disable iff (reset) accept |=> !req_tready)
      else $error("second transaction accepted while a sample is being computed");

   assert property (@(posedge clock) disable iff (reset)
                    out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before its transaction completed");

   assert property (@(posedge clock) disable iff (reset)
                    (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == OUT_MAX || rsp_tdata == OUT_MIN))
      else $error("clipped sample is not at a full-scale rail");

endmodule
